// ===== sv/cqr_pkg.sv =====
// Shared types and constants of the commit quorum block.
package cqr_pkg;

   // Most results that one vote may produce.
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS);

   // Fixed field widths of the channels.
   localparam int SLOT_W   = 32;
   localparam int VOTER_W  = 4;
   localparam int STATUS_W = 3;
   localparam int FT_W     = 3;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_RECORDED  = 3'd0,
      ST_RELEASED  = 3'd1,
      ST_STALE     = 3'd2,
      ST_BEYOND    = 3'd3,
      ST_DUPLICATE = 3'd4
   } cqr_status_type;

   // One classified vote as it waits between the front and the back.
   typedef struct packed {
      logic                is_record;
      cqr_status_type      status;
      logic [VOTER_W-1:0]  voter;
   } cqr_cmd_type;

   // What the back reports to the front.
   typedef struct packed {
      logic [SLOT_W-1:0] head_slot;
      logic              rec_done;
   } cqr_ptr_type;

   // Back sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_CHECK = 3'b010,
      BK_WALK  = 3'b100
   } cqr_back_state_type;

endpackage

// ===== sv/cqr_req_if.sv =====
// Vote channel: valid/ready handshake with slot number and voter id.
interface cqr_req_if import cqr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  vote_slot;
   logic [VOTER_W-1:0] voter_id;

   modport source (output valid, output vote_slot, output voter_id, input ready);
   modport sink   (input valid, input vote_slot, input voter_id, output ready);
endinterface

// ===== sv/cqr_rsp_if.sv =====
// Result channel: valid/ready handshake with status, released slot and last flag.
interface cqr_rsp_if import cqr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   released_slot;
   logic                last;

   modport source (output valid, output status, output released_slot, output last,
                   input ready);
   modport sink   (input valid, input status, input released_slot, input last,
                   output ready);
endinterface

// ===== sv/cqr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cqr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/cqr_fifo.sv =====
// Short first-in first-out queue between the front and the back.
module cqr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== sv/cqr_front.sv =====
// Front: takes votes in, checks them against the window and queues a command.
module cqr_front import cqr_pkg::*; #(
   parameter int MAX_REPLICAS = 16,
   parameter int SLOT_WINDOW  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   cqr_req_if.sink                        req,
   input  cqr_ptr_type                    ptr,
   input  logic [$clog2(SLOT_WINDOW)-1:0] head_idx,
   output logic                           push_valid,
   input  logic                           push_ready,
   output cqr_cmd_type                    push_cmd,
   output logic [$clog2(SLOT_WINDOW)-1:0] push_idx
);
   localparam int IDX_W = $clog2(SLOT_WINDOW);
   localparam int RW    = $clog2(MAX_REPLICAS + 1) + 1;

   logic               hold_valid_ff, hold_valid_in;
   logic               rec_busy_ff, rec_busy_in;
   logic [SLOT_W-1:0]  hold_slot_ff;
   logic [VOTER_W-1:0] hold_voter_ff;

   logic               classify;
   logic               is_stale, in_window, voter_ok;
   logic [SLOT_W-1:0]  slot_gap;
   logic [IDX_W:0]     idx_sum;

   // A recorded vote may move the window, so nothing else is classified
   // until the back reports it finished.
   assign classify  = hold_valid_ff && !rec_busy_ff && push_ready;
   assign req.ready = !hold_valid_ff || classify;

   assign is_stale  = hold_slot_ff < ptr.head_slot;
   assign slot_gap  = hold_slot_ff - ptr.head_slot;
   assign in_window = slot_gap < SLOT_W'(SLOT_WINDOW);
   assign voter_ok  = RW'(hold_voter_ff) < RW'(MAX_REPLICAS);
   assign idx_sum   = (IDX_W + 1)'(head_idx) + (IDX_W + 1)'(slot_gap[IDX_W-1:0]);

   always_comb begin
      push_cmd.voter     = hold_voter_ff;
      push_cmd.is_record = 1'b0;
      push_cmd.status    = ST_RECORDED;
      if (is_stale) begin
         push_cmd.status = ST_STALE;
      end else if (!in_window) begin
         push_cmd.status = ST_BEYOND;
      end else if (voter_ok) begin
         push_cmd.is_record = 1'b1;
      end
      if (idx_sum >= (IDX_W + 1)'(SLOT_WINDOW)) begin
         push_idx = IDX_W'(idx_sum - (IDX_W + 1)'(SLOT_WINDOW));
      end else begin
         push_idx = idx_sum[IDX_W-1:0];
      end
   end

   assign push_valid = classify;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      rec_busy_in   = rec_busy_ff;
      if (classify) begin
         hold_valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         hold_valid_in = 1'b1;
      end
      if (ptr.rec_done) begin
         rec_busy_in = 1'b0;
      end
      if (classify && push_cmd.is_record) begin
         rec_busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rec_busy_ff   <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rec_busy_ff   <= rec_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         hold_slot_ff  <= req.vote_slot;
         hold_voter_ff <= req.voter_id;
      end
   end
endmodule

// ===== sv/cqr_back.sv =====
// Back: records votes in the window store and releases committed slots in order.
module cqr_back import cqr_pkg::*; #(
   parameter int MAX_REPLICAS = 16,
   parameter int SLOT_WINDOW  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [FT_W-1:0]                fault_tolerance,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  cqr_cmd_type                    pop_cmd,
   input  logic [$clog2(SLOT_WINDOW)-1:0] pop_idx,
   cqr_rsp_if.source                      rsp,
   output cqr_ptr_type                    ptr,
   output logic [$clog2(SLOT_WINDOW)-1:0] head_idx
);
   localparam int IDX_W = $clog2(SLOT_WINDOW);
   localparam int VW    = $clog2(MAX_REPLICAS);
   localparam int CW    = $clog2(MAX_REPLICAS + 1);
   localparam int QW    = (CW > FT_W + 1) ? CW : FT_W + 1;
   localparam int EW    = MAX_REPLICAS + CW;

   cqr_back_state_type state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [VW-1:0]          voter_ff, voter_in;
   logic [RES_CNT_W-1:0]   n_ff, n_in;
   logic [SLOT_W-1:0]      next_ff, next_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [SLOT_WINDOW-1:0] flag_ff, flag_in;
   logic [SLOT_WINDOW-1:0] valid_ff, valid_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   cqr_status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   emit;

   logic                   ram_wr_en, ram_rd_en;
   logic [EW-1:0]          ram_wr_data, ram_rd_data;

   logic [EW-1:0]          entry;
   logic [MAX_REPLICAS-1:0] bitmap, voter_bit;
   logic [CW-1:0]          count, count_nx;
   logic [QW-1:0]          quorum;
   logic                   out_free, rec_done;
   logic [SLOT_W-1:0]      slot_nx;
   logic [IDX_W-1:0]       head_nx;
   logic                   walk_last;

   cqr_ram #(.WIDTH(EW), .DEPTH(SLOT_WINDOW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (pop_idx),
      .rd_data (ram_rd_data)
   );

   // An entry whose valid bit is clear reads as an empty bitmap.
   assign entry     = valid_ff[idx_ff] ? ram_rd_data : '0;
   assign bitmap    = entry[MAX_REPLICAS-1:0];
   assign count     = entry[EW-1:MAX_REPLICAS];
   assign count_nx  = count + CW'(1);
   assign voter_bit = MAX_REPLICAS'(1) << voter_ff;
   assign quorum    = QW'({fault_tolerance, 1'b1});
   assign ram_wr_data = {count_nx, bitmap | voter_bit};

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign slot_nx   = next_ff + SLOT_W'(1);
   assign head_nx   = (slot_nx == '0 || head_ff == IDX_W'(SLOT_WINDOW - 1)) ?
                      '0 : head_ff + IDX_W'(1);
   assign walk_last = (n_ff == RES_CNT_W'(MAX_RESULTS - 1)) || (slot_nx == '0) ||
                      !flag_ff[head_nx];

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      voter_in      = voter_ff;
      n_in          = n_ff;
      next_in       = next_ff;
      head_in       = head_ff;
      flag_in       = flag_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      emit          = 1'b0;
      pop_ready     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      rec_done      = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = out_free;
            if (pop_valid && out_free) begin
               if (pop_cmd.is_record) begin
                  ram_rd_en = 1'b1;
                  idx_in    = pop_idx;
                  voter_in  = VW'(pop_cmd.voter);
                  state_in  = BK_CHECK;
               end else begin
                  emit          = 1'b1;
                  rsp_status_in = pop_cmd.status;
                  rsp_slot_in   = '0;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         BK_CHECK: begin
            if ((bitmap & voter_bit) != '0) begin
               if (out_free) begin
                  emit          = 1'b1;
                  rsp_status_in = ST_DUPLICATE;
                  rsp_slot_in   = '0;
                  rsp_last_in   = 1'b1;
                  rec_done      = 1'b1;
                  state_in      = BK_IDLE;
               end
            end else begin
               ram_wr_en        = 1'b1;
               valid_in[idx_ff] = 1'b1;
               if (QW'(count_nx) >= quorum) begin
                  flag_in[idx_ff] = 1'b1;
               end
               n_in     = '0;
               state_in = BK_WALK;
            end
         end
         BK_WALK: begin
            if (out_free) begin
               emit     = 1'b1;
               rsp_last_in = 1'b1;
               if (flag_ff[head_ff]) begin
                  rsp_status_in     = ST_RELEASED;
                  rsp_slot_in       = next_ff;
                  rsp_last_in       = walk_last;
                  flag_in[head_ff]  = 1'b0;
                  valid_in[head_ff] = 1'b0;
                  next_in           = slot_nx;
                  head_in           = head_nx;
                  n_in              = n_ff + RES_CNT_W'(1);
                  if (walk_last) begin
                     rec_done = 1'b1;
                     state_in = BK_IDLE;
                  end
               end else begin
                  rsp_status_in = ST_RECORDED;
                  rsp_slot_in   = '0;
                  rec_done      = 1'b1;
                  state_in      = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         n_ff         <= '0;
         next_ff      <= '0;
         head_ff      <= '0;
         flag_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         next_ff      <= next_in;
         head_ff      <= head_in;
         flag_ff      <= flag_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      voter_ff      <= voter_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.released_slot = rsp_slot_ff;
   assign rsp.last          = rsp_last_ff;

   assign ptr.head_slot = next_ff;
   assign ptr.rec_done  = rec_done;
   assign head_idx      = head_ff;
endmodule

// ===== sv/commit_quorum_in_order_release.sv =====
// Top level of the commit quorum block with in-order slot release.
//
//   Channel   Direction  Handshake       Carries
//   req_if    in         valid / ready   vote_slot, voter_id
//   rsp_if    out        valid / ready   status, released_slot, last
//   csr_*     in         write enable    fault_tolerance (3 bits, reset 1)
//
// A vote passes through the front's input register and the queue. A dropped
// vote (stale or beyond the window) is then answered from the back's idle state;
// a recorded vote goes through the window store read, the check and update, and,
// unless it is a duplicate, one result per released slot (a single recorded result
// when none is released). The front holds the next vote until a recorded vote has
// finished, since its release run moves the window.
// Reset is synchronous and clears the window at once through per-entry valid
// bits, so no clearing pass is needed. A stalled result channel holds the
// back; the front keeps accepting until its input register is full and can
// not be passed on, because the queue is full or a recorded vote is pending.
module commit_quorum_in_order_release import cqr_pkg::*; #(
   parameter int MAX_REPLICAS = 16,
   parameter int SLOT_WINDOW  = 16
) (
   input  logic            clock,
   input  logic            reset,
   cqr_req_if.sink         req_if,
   cqr_rsp_if.source       rsp_if,
   input  logic            csr_wr_en,
   input  logic [FT_W-1:0] csr_wr_data
);
   localparam int IDX_W   = $clog2(SLOT_WINDOW);
   localparam int Q_DEPTH = 2;
   localparam int Q_W     = $bits(cqr_cmd_type) + IDX_W;

   // The fault tolerance register; the quorum is twice this plus one.
   logic [FT_W-1:0] fault_tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_tolerance_ff <= FT_W'(1);
      end else if (csr_wr_en) begin
         fault_tolerance_ff <= csr_wr_data;
      end
   end

   cqr_ptr_type      ptr;
   logic [IDX_W-1:0] head_idx;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   cqr_cmd_type      push_cmd, pop_cmd;
   logic [IDX_W-1:0] push_idx, pop_idx;

   // The front checks each vote against the current window and computes
   // its entry index from the head entry, so no modulo of the slot is needed.
   cqr_front #(.MAX_REPLICAS(MAX_REPLICAS), .SLOT_WINDOW(SLOT_WINDOW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .ptr        (ptr),
      .head_idx   (head_idx),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .push_idx   (push_idx)
   );

   // Classified votes wait here so that either side can stall on its own.
   cqr_fifo #(.WIDTH(Q_W), .DEPTH(Q_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_cmd, push_idx}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   ({pop_cmd, pop_idx})
   );

   // The back owns the voter store, the quorum flags and the release pointer,
   // and drives the result register.
   cqr_back #(.MAX_REPLICAS(MAX_REPLICAS), .SLOT_WINDOW(SLOT_WINDOW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .fault_tolerance (fault_tolerance_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_cmd         (pop_cmd),
      .pop_idx         (pop_idx),
      .rsp             (rsp_if),
      .ptr             (ptr),
      .head_idx        (head_idx)
   );
endmodule

// ===== sv/cqr_checker.sv =====
// Port-level checks for the commit quorum block, bound to its top level.
module cqr_checker import cqr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SLOT_W-1:0]   rsp_released_slot,
   input logic                rsp_last
);
   logic              rsp_xfer;
   logic              is_release;
   logic [SLOT_W-1:0] expect_slot_ff;

   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign is_release = rsp_status == ST_RELEASED;

   // Released slots follow one another across all votes, from zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_slot_ff <= '0;
      end else if (rsp_xfer && is_release) begin
         expect_slot_ff <= rsp_released_slot + SLOT_W'(1);
      end
   end

   a_release_order: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && is_release |-> rsp_released_slot == expect_slot_ff)
      else $error("released slot out of order");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_release |-> rsp_released_slot == '0)
      else $error("released slot set on a result that releases nothing");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_release |-> rsp_last)
      else $error("non-release result is not the final one of its vote");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_released_slot) && $stable(rsp_last))
      else $error("stalled result changed");
endmodule

bind commit_quorum_in_order_release cqr_checker u_cqr_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_released_slot (rsp_if.released_slot),
   .rsp_last          (rsp_if.last)
);

// ===== dv/commit_quorum_in_order_release_test.sv =====
// Self-checking testbench for the commit quorum block with in-order slot release.
`timescale 1ns / 1ps

module commit_quorum_in_order_release_test;
   import cqr_pkg::*;

   localparam int MAX_REPLICAS = 16;
   localparam int SLOT_WINDOW  = 16;
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_VOTES  = 44;
   localparam int HOLD_CYCLES  = 400;
   localparam int SCRIPT_LEN   = 24;

   // One result as the block should deliver it.
   typedef struct packed {
      cqr_status_type    status;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } vote_outcome_type;

   // One row of the directed script. When known is set, the row yields a single
   // result with the given status, which is typed in by hand; otherwise the
   // tally below decides.
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [VOTER_W-1:0] voter;
      logic               known;
      cqr_status_type     status;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [FT_W-1:0] csr_wr_data;

   cqr_req_if req_if ();
   cqr_rsp_if rsp_if ();

   commit_quorum_in_order_release #(
      .MAX_REPLICAS(MAX_REPLICAS),
      .SLOT_WINDOW (SLOT_WINDOW)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // The testbench's own copy of the vote tally. It starts out in the state the
   // block has after reset: empty window, release pointer at slot zero and a
   // fault tolerance of one.
   logic [MAX_REPLICAS-1:0] tally_voters [SLOT_WINDOW] = '{default: '0};
   logic                    tally_committed [SLOT_WINDOW] = '{default: 1'b0};
   logic [SLOT_W-1:0]       tally_next = '0;
   logic [FT_W-1:0]         tally_ft = 3'd1;

   // Results of the vote most recently tallied, and all results still owed by
   // the block, oldest first.
   vote_outcome_type step_outcomes [$];
   vote_outcome_type awaited_outcomes [$];
   vote_outcome_type want;

   int  votes_sent = 0;
   int  mismatch_count = 0;
   int  send_idle_pct = 0;
   int  rcv_idle_pct = 0;
   bit  hold_go = 1'b0;
   logic rsp_hold = 1'b0;

   // Directed script, walked at the default fault tolerance of one (quorum of
   // three). It covers every status code, the window edges, the slot and voter
   // extremes, a vote arriving after its slot reached quorum, a committed slot
   // held back behind an uncommitted head, and a release run of two slots.
   script_row_type script [SCRIPT_LEN] = '{
      '{32'd0,          4'd0,  1'b1, ST_RECORDED},
      '{32'd0,          4'd0,  1'b1, ST_DUPLICATE},
      '{32'd16,         4'd1,  1'b1, ST_BEYOND},
      '{32'hFFFF_FFFF,  4'd15, 1'b1, ST_BEYOND},
      '{32'd15,         4'd15, 1'b1, ST_RECORDED},
      '{32'd1,          4'd3,  1'b1, ST_RECORDED},
      '{32'd1,          4'd4,  1'b1, ST_RECORDED},
      '{32'd1,          4'd5,  1'b0, ST_RECORDED},
      '{32'd1,          4'd6,  1'b0, ST_RECORDED},
      '{32'd0,          4'd1,  1'b1, ST_RECORDED},
      '{32'd0,          4'd2,  1'b0, ST_RECORDED},
      '{32'd0,          4'd7,  1'b1, ST_STALE},
      '{32'd1,          4'd7,  1'b1, ST_STALE},
      '{32'd17,         4'd0,  1'b1, ST_RECORDED},
      '{32'd18,         4'd0,  1'b1, ST_BEYOND},
      '{32'd3,          4'd0,  1'b1, ST_RECORDED},
      '{32'd3,          4'd1,  1'b1, ST_RECORDED},
      '{32'd3,          4'd2,  1'b0, ST_RECORDED},
      '{32'd3,          4'd8,  1'b0, ST_RECORDED},
      '{32'd2,          4'd15, 1'b1, ST_RECORDED},
      '{32'd2,          4'd14, 1'b1, ST_RECORDED},
      '{32'd2,          4'd13, 1'b0, ST_RECORDED},
      '{32'hAAAA_AAAA,  4'd10, 1'b1, ST_BEYOND},
      '{32'h5555_5555,  4'd5,  1'b1, ST_BEYOND}
   };

   // Fault tolerance used in each random phase. Both ends of the register range
   // appear; with seven the quorum is fifteen of the sixteen replicas.
   logic [FT_W-1:0] phase_ft [NUM_PHASES] = '{3'd0, 3'd7, 3'd3, 3'd5, 3'd1,
                                              3'd6, 3'd2, 3'd4, 3'd0};

   // Appends one result to those of the vote being tallied.
   function automatic void owe_step(input vote_outcome_type outcome);
      step_outcomes.insert(step_outcomes.size(), outcome);
   endfunction

   // Tallies one accepted vote and leaves the results it causes in
   // step_outcomes. The window check is done in 33 bits so that it never wraps.
   // The release pointer wrapping past the top of the slot space is handled,
   // although no run from reset can get that far.
   function automatic void tally_vote(input logic [SLOT_W-1:0]  slot,
                                      input logic [VOTER_W-1:0] voter);
      logic [3:0] entry;
      logic [3:0] head;
      int         run;
      step_outcomes.delete();
      if (slot < tally_next) begin
         owe_step(vote_outcome_type'{ST_STALE, '0, 1'b1});
      end else if (({1'b0, slot} - {1'b0, tally_next}) >= 33'(SLOT_WINDOW)) begin
         owe_step(vote_outcome_type'{ST_BEYOND, '0, 1'b1});
      end else begin
         entry = 4'(slot % SLOT_WINDOW);
         if (tally_voters[entry][voter]) begin
            owe_step(vote_outcome_type'{ST_DUPLICATE, '0, 1'b1});
         end else begin
            tally_voters[entry][voter] = 1'b1;
            if (!tally_committed[entry] &&
                $countones(tally_voters[entry]) >= 2 * int'(tally_ft) + 1) begin
               tally_committed[entry] = 1'b1;
            end
            // Release committed slots in order from the head of the window.
            run = 0;
            while (run < MAX_RESULTS) begin
               head = 4'(tally_next % SLOT_WINDOW);
               if (!tally_committed[head]) break;
               owe_step(vote_outcome_type'{ST_RELEASED, tally_next, 1'b0});
               tally_committed[head] = 1'b0;
               tally_voters[head] = '0;
               tally_next = tally_next + SLOT_W'(1);
               run++;
               if (tally_next == '0) break;
            end
            if (run == 0) begin
               owe_step(vote_outcome_type'{ST_RECORDED, '0, 1'b1});
            end else begin
               step_outcomes[run-1].last = 1'b1;
            end
         end
      end
   endfunction

   // Offers one vote, after a random number of idle cycles, and waits for the
   // transfer. The vote is tallied at the edge where it is taken.
   task automatic send_vote(input logic [SLOT_W-1:0]  slot,
                            input logic [VOTER_W-1:0] voter,
                            input logic               known = 1'b0,
                            input cqr_status_type     known_status = ST_RECORDED);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.vote_slot <= slot;
      req_if.voter_id  <= voter;
      do @(posedge clock); while (!req_if.ready);
      tally_vote(slot, voter);
      if (known) begin
         awaited_outcomes.insert(awaited_outcomes.size(),
                                 vote_outcome_type'{known_status, '0, 1'b1});
      end else begin
         foreach (step_outcomes[i]) begin
            awaited_outcomes.insert(awaited_outcomes.size(), step_outcomes[i]);
         end
      end
      votes_sent++;
   endtask

   // Stops offering votes and waits until every owed result has come.
   task automatic await_outcomes();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   // A well-formed round for one slot: a quorum of distinct voters in random
   // order, now and then a repeated voter, and sometimes a few votes past quorum.
   task automatic fill_slot(input logic [SLOT_W-1:0] target);
      logic [VOTER_W-1:0] order [MAX_REPLICAS];
      logic [VOTER_W-1:0] swap;
      int                 pick;
      int                 quorum;
      int                 extra;
      for (int i = 0; i < MAX_REPLICAS; i++) order[i] = VOTER_W'(i);
      for (int i = MAX_REPLICAS - 1; i > 0; i--) begin
         pick = int'($urandom_range(i));
         swap = order[i];
         order[i] = order[pick];
         order[pick] = swap;
      end
      quorum = 2 * int'(tally_ft) + 1;
      extra = ($urandom_range(3) == 0) ? int'($urandom_range(2)) : 0;
      for (int i = 0; i < quorum + extra && i < MAX_REPLICAS; i++) begin
         send_vote(target, order[i]);
         if ($urandom_range(9) == 0) send_vote(target, order[$urandom_range(i)]);
      end
   endtask

   // Commits every slot of the window behind the head and then the head itself,
   // so that the vote that commits the head releases the whole window in one run.
   task automatic fill_window();
      logic [SLOT_W-1:0] base;
      base = tally_next;
      for (int k = 1; k < SLOT_WINDOW; k++) fill_slot(base + SLOT_W'(k));
      fill_slot(base);
   endtask

   // Random votes: mostly quorum rounds near the head of the window, the rest
   // stale votes, votes past the window and single votes scattered in it.
   task automatic run_phase(input int budget);
      int stop;
      int pick;
      stop = votes_sent + budget;
      if (tally_ft == '0) fill_window();
      while (votes_sent < stop) begin
         pick = int'($urandom_range(99));
         if (pick < 70) begin
            fill_slot(tally_next + SLOT_W'(($urandom_range(2) == 0) ?
                                           $urandom_range(SLOT_WINDOW - 1) : 0));
         end else if (pick < 80 && tally_next != '0) begin
            send_vote(SLOT_W'($urandom_range(tally_next - 1)),
                      VOTER_W'($urandom_range(15)));
         end else if (pick < 90) begin
            send_vote($urandom_range(1) ?
                         tally_next + SLOT_W'(SLOT_WINDOW) + SLOT_W'($urandom_range(40)) :
                         SLOT_W'($urandom),
                      VOTER_W'($urandom_range(15)));
         end else begin
            send_vote(tally_next + SLOT_W'($urandom_range(SLOT_WINDOW - 1)),
                      VOTER_W'($urandom_range(15)));
         end
      end
   endtask

   // Result side: check every transfer against the oldest owed result, field by
   // field, and drive ready at random unless a long hold is in force.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_outcomes.size() == 0) begin
            $display("%0t: result with nothing owed: status %0d slot %0d last %0d",
                     $time, rsp_if.status, rsp_if.released_slot, rsp_if.last);
            mismatch_count++;
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_if.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_if.status);
               mismatch_count++;
            end
            if (rsp_if.released_slot !== want.slot) begin
               $display("%0t: released_slot expected %0d actual %0d",
                        $time, want.slot, rsp_if.released_slot);
               mismatch_count++;
            end
            if (rsp_if.last !== want.last) begin
               $display("%0t: last expected %0d actual %0d",
                        $time, want.last, rsp_if.last);
               mismatch_count++;
            end
         end
      end
      rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= rcv_idle_pct);
   end

   // Long hold of the result side, counted here, while the sender keeps
   // offering votes; the block has to fill up and stop taking votes.
   initial begin
      wait (hold_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Stimulus and verdict.
   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.vote_slot <= '0;
      req_if.voter_id  <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      rcv_idle_pct  = 45;
      foreach (script[i]) begin
         send_vote(script[i].slot, script[i].voter, script[i].known, script[i].status);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // The register is only written with nothing in flight.
         await_outcomes();
         if (phase < 3) begin
            send_idle_pct = 37;
            rcv_idle_pct  = 45;
         end else if (phase < 6) begin
            send_idle_pct = 45;
            rcv_idle_pct  = 37;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_ft[phase];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         tally_ft = phase_ft[phase];

         if (phase == 1) hold_go = 1'b1;
         if (phase == 4) begin
            // Let the block drain completely halfway through this phase.
            run_phase(PHASE_VOTES / 2);
            await_outcomes();
            run_phase(PHASE_VOTES / 2);
         end else begin
            run_phase(PHASE_VOTES);
         end
      end

      await_outcomes();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
